[sv/pnsc_pkg.sv]
// shared constants, types and the soft-knee table builder for the peak normalizer
package pnsc_pkg;

	// item field widths
	localparam int SAMPLE_W = 21;
	localparam int OUT_W    = 16;
	localparam int VOL_W    = 8;

	// block store geometry
	localparam int BLOCK_SAMPLES = 1024;
	localparam int ADDR_W        = $clog2(BLOCK_SAMPLES);
	localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1);

	// peak tracking and scale
	localparam int PEAK_W      = SAMPLE_W;
	localparam int SCALE_FRAC  = 16;
	localparam int SCALE_W     = SCALE_FRAC + 1;
	localparam int DIV_CW      = $clog2(SCALE_FRAC);
	localparam logic [PEAK_W-1:0]  PEAK_THRESHOLD = PEAK_W'(34405);
	localparam logic [SCALE_W-1:0] UNITY_SCALE    = SCALE_W'(65536);
	localparam int FULL_SCALE  = 32767;

	// shared multiplier operand and product widths
	localparam int MUL_BW = SCALE_W + 1;
	localparam int PROD_W = SAMPLE_W + MUL_BW;
	localparam int B_W    = PROD_W - SCALE_FRAC;

	// soft-knee table
	localparam int CLIP_TABLE_DEPTH = 2048;
	localparam int KNEE_AW          = $clog2(CLIP_TABLE_DEPTH);
	localparam int KNEE_W           = 16;

	typedef logic [KNEE_W-1:0] knee_table_t [CLIP_TABLE_DEPTH];

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MULV,
		ST_MULS,
		ST_CLIP,
		ST_EMIT
	} state_t;

	// input opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_PULL = 1'b1;

	localparam logic [63:0] KNEE_FS = 64'(FULL_SCALE);

	// floor(32767*(1-exp(-d/32767))) by the alternating series in Q32
	function automatic logic [KNEE_W-1:0] soft_knee(input logic [63:0] d);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] diff;
		term = d << 32;
		pos  = term;
		term = (term * d) / (2 * KNEE_FS);
		neg  = term;
		term = (term * d) / (3 * KNEE_FS);
		pos  = pos + term;
		term = (term * d) / (4 * KNEE_FS);
		neg  = neg + term;
		term = (term * d) / (5 * KNEE_FS);
		pos  = pos + term;
		term = (term * d) / (6 * KNEE_FS);
		neg  = neg + term;
		term = (term * d) / (7 * KNEE_FS);
		pos  = pos + term;
		term = (term * d) / (8 * KNEE_FS);
		neg  = neg + term;
		term = (term * d) / (9 * KNEE_FS);
		pos  = pos + term;
		term = (term * d) / (10 * KNEE_FS);
		neg  = neg + term;
		term = (term * d) / (11 * KNEE_FS);
		pos  = pos + term;
		term = (term * d) / (12 * KNEE_FS);
		neg  = neg + term;
		diff = pos - neg;
		return diff[32 +: KNEE_W];
	endfunction

	// whole table, evaluated at elaboration
	function automatic knee_table_t build_knee_table();
		knee_table_t tbl;
		for (int i = 0; i < CLIP_TABLE_DEPTH; i++) begin
			tbl[i] = soft_knee(64'(i));
		end
		return tbl;
	endfunction

endpackage

[sv/pnsc_if.sv]
// valid/ready channel interfaces for sample items in and limited samples out

interface pnsc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  opcode;
	logic signed [pnsc_pkg::SAMPLE_W-1:0]  mixed_sample;
	logic                                  block_end;

	modport source (output valid, output opcode, output mixed_sample, output block_end,
		input ready);
	modport sink (input valid, input opcode, input mixed_sample, input block_end,
		output ready);
endinterface

interface pnsc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pnsc_pkg::OUT_W-1:0]  limited_sample;
	logic                               block_last;

	modport source (output valid, output limited_sample, output block_last, input ready);
	modport sink (input valid, input limited_sample, input block_last, output ready);
endinterface

[sv/pnsc_knee_rom.sv]
// soft-knee lookup rom with registered read
module pnsc_knee_rom (
	input  logic                         clk,
	input  logic [pnsc_pkg::KNEE_AW-1:0] addr,
	output logic [pnsc_pkg::KNEE_W-1:0]  knee
);

	localparam pnsc_pkg::knee_table_t KNEE_ROM = pnsc_pkg::build_knee_table();

	logic [pnsc_pkg::KNEE_W-1:0] knee_q;

	// registered table read
	always_ff @(posedge clk) begin
		knee_q <= KNEE_ROM[addr];
	end

	assign knee = knee_q;

endmodule

[sv/peak_normalize_soft_clip_stage.sv]
// Peak normalizer with soft clip: pushes load a block of up to 1024 samples and
// track the peak magnitude; a push flagged block_end closes the block. Closing
// a block whose peak exceeds 34405 runs a restoring divider that produces one
// bit of the Q16 scale per cycle. A pull passes store read, two passes through
// the one shared multiplier (volume, then scale), soft-knee table read and an
// output load that waits for a free output register. The block takes one item
// at a time; pulls during loading and pushes during draining are taken and have
// no effect. The sample store needs no clearing after reset.
module peak_normalize_soft_clip_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pnsc_pkg::VOL_W-1:0]   cfg_wdata,
	pnsc_in_if.sink                      sample_in,
	pnsc_out_if.source                   sample_out
);

	pnsc_pkg::state_t state_q;
	pnsc_pkg::state_t state_d;

	// control registers
	logic [pnsc_pkg::VOL_W-1:0]   vol_q;
	logic [pnsc_pkg::CNT_W-1:0]   fill_q;
	logic [pnsc_pkg::CNT_W-1:0]   read_q;
	logic [pnsc_pkg::PEAK_W-1:0]  peak_q;
	logic [pnsc_pkg::SCALE_W-1:0] scale_q;
	logic                         draining_q;
	logic [pnsc_pkg::DIV_CW-1:0]  div_cnt_q;
	logic                         out_valid_q;

	// payload registers
	logic signed [pnsc_pkg::SAMPLE_W-1:0] store_q [pnsc_pkg::BLOCK_SAMPLES];
	logic signed [pnsc_pkg::SAMPLE_W-1:0] data_q;
	logic signed [pnsc_pkg::PROD_W-1:0]   prod_q;
	logic [pnsc_pkg::PEAK_W-1:0]          rem_q;
	logic [pnsc_pkg::SCALE_FRAC-1:0]      quo_q;
	logic                                 last_q;
	logic                                 over_q;
	logic                                 under_q;
	logic [pnsc_pkg::OUT_W-1:0]           b16_q;
	logic [pnsc_pkg::OUT_W-1:0]           out_sample_q;
	logic                                 out_last_q;

	// control outputs of the sequencer
	logic in_ready;
	logic out_free;
	logic out_load;
	logic mul_scale_pass;
	logic div_last;

	// input decode
	logic                        accept;
	logic                        push_ok;
	logic                        store_ok;
	logic                        pull_ok;
	logic [pnsc_pkg::PEAK_W-1:0] mag;
	logic [pnsc_pkg::PEAK_W-1:0] peak_new;
	logic [pnsc_pkg::CNT_W-1:0]  fill_new;
	logic                        close_ok;
	logic                        need_div;

	assign accept   = sample_in.valid && in_ready;
	assign push_ok  = accept && (sample_in.opcode == pnsc_pkg::OP_PUSH) && !draining_q;
	assign store_ok = push_ok && (fill_q != pnsc_pkg::CNT_W'(pnsc_pkg::BLOCK_SAMPLES));
	assign pull_ok  = accept && (sample_in.opcode == pnsc_pkg::OP_PULL) && draining_q
		&& (read_q < fill_q);

	// magnitude and running peak
	assign mag = sample_in.mixed_sample[pnsc_pkg::SAMPLE_W-1]
		? pnsc_pkg::PEAK_W'(~sample_in.mixed_sample + 1'b1)
		: pnsc_pkg::PEAK_W'(sample_in.mixed_sample);
	assign peak_new = (store_ok && (mag > peak_q)) ? mag : peak_q;
	assign fill_new = store_ok ? fill_q + 1'b1 : fill_q;
	assign close_ok = push_ok && sample_in.block_end && (fill_new != '0);
	assign need_div = peak_new > pnsc_pkg::PEAK_THRESHOLD;

	// divider step: shift remainder, subtract peak when it fits
	logic [pnsc_pkg::PEAK_W:0]   rem_sh;
	logic [pnsc_pkg::PEAK_W:0]   rem_diff;
	logic                        rem_ge;
	logic [pnsc_pkg::SCALE_FRAC-1:0] quo_new;

	assign rem_sh   = {rem_q, 1'b0};
	assign rem_diff = rem_sh - {1'b0, peak_q};
	assign rem_ge   = rem_sh >= {1'b0, peak_q};
	assign quo_new  = {quo_q[pnsc_pkg::SCALE_FRAC-2:0], rem_ge};

	// shared multiplier
	logic signed [pnsc_pkg::SAMPLE_W-1:0] mul_a;
	logic signed [pnsc_pkg::MUL_BW-1:0]   mul_b;
	logic signed [pnsc_pkg::PROD_W-1:0]   mul_p;

	assign mul_a = mul_scale_pass
		? prod_q[8 +: pnsc_pkg::SAMPLE_W]
		: data_q;
	assign mul_b = mul_scale_pass
		? $signed({1'b0, scale_q})
		: $signed(pnsc_pkg::MUL_BW'(vol_q));
	assign mul_p = pnsc_pkg::PROD_W'(mul_a) * pnsc_pkg::PROD_W'(mul_b);

	// truncate toward zero, find overshoot distance
	logic signed [pnsc_pkg::PROD_W-1:0] biased;
	logic signed [pnsc_pkg::B_W-1:0]    b_val;
	logic                               over;
	logic                               under;
	logic signed [pnsc_pkg::B_W-1:0]    ovr_dist;
	logic [pnsc_pkg::KNEE_AW-1:0]       knee_addr;
	logic [pnsc_pkg::KNEE_W-1:0]        knee;

	assign biased = prod_q + (prod_q[pnsc_pkg::PROD_W-1]
		? pnsc_pkg::PROD_W'(65535) : pnsc_pkg::PROD_W'(0));
	assign b_val  = biased[pnsc_pkg::PROD_W-1 -: pnsc_pkg::B_W];
	assign over   = b_val > pnsc_pkg::B_W'(32767);
	assign under  = b_val < -pnsc_pkg::B_W'(32768);
	assign ovr_dist = over ? b_val - pnsc_pkg::B_W'(32767)
		: -pnsc_pkg::B_W'(32768) - b_val;
	assign knee_addr = (ovr_dist >= pnsc_pkg::B_W'(pnsc_pkg::CLIP_TABLE_DEPTH))
		? pnsc_pkg::KNEE_AW'(pnsc_pkg::CLIP_TABLE_DEPTH - 1)
		: ovr_dist[pnsc_pkg::KNEE_AW-1:0];

	pnsc_knee_rom u_knee_rom (
		.clk  (clk),
		.addr (knee_addr),
		.knee (knee)
	);

	// final fold-back of overshoot
	logic [pnsc_pkg::OUT_W-1:0] result;

	always_comb begin
		if (over_q) begin
			result = 16'h7FFF - knee;
		end else if (under_q) begin
			result = 16'h8000 + knee;
		end else begin
			result = b16_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pnsc_pkg::ST_IDLE: begin
				if (pull_ok) begin
					state_d = pnsc_pkg::ST_MULV;
				end else if (close_ok && need_div) begin
					state_d = pnsc_pkg::ST_DIV;
				end
			end
			pnsc_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = pnsc_pkg::ST_IDLE;
				end
			end
			pnsc_pkg::ST_MULV: state_d = pnsc_pkg::ST_MULS;
			pnsc_pkg::ST_MULS: state_d = pnsc_pkg::ST_CLIP;
			pnsc_pkg::ST_CLIP: state_d = pnsc_pkg::ST_EMIT;
			pnsc_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = pnsc_pkg::ST_IDLE;
				end
			end
			default: state_d = pnsc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready       = 1'b0;
		mul_scale_pass = 1'b0;
		out_load       = 1'b0;
		div_last       = 1'b0;
		out_free       = !out_valid_q || sample_out.ready;
		case (state_q)
			pnsc_pkg::ST_IDLE: in_ready = 1'b1;
			pnsc_pkg::ST_DIV:  div_last = (div_cnt_q == pnsc_pkg::DIV_CW'(pnsc_pkg::SCALE_FRAC - 1));
			pnsc_pkg::ST_MULS: mul_scale_pass = 1'b1;
			pnsc_pkg::ST_EMIT: out_load = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pnsc_pkg::ST_IDLE;
			vol_q       <= pnsc_pkg::VOL_W'(255);
			fill_q      <= '0;
			read_q      <= '0;
			peak_q      <= '0;
			scale_q     <= pnsc_pkg::UNITY_SCALE;
			draining_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vol_q <= cfg_wdata;
			end
			// loading
			if (push_ok) begin
				fill_q <= fill_new;
				peak_q <= peak_new;
			end
			if (close_ok) begin
				read_q    <= '0;
				div_cnt_q <= '0;
				if (!need_div) begin
					scale_q    <= pnsc_pkg::UNITY_SCALE;
					draining_q <= 1'b1;
				end
			end
			// scale division
			if (state_q == pnsc_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_last) begin
					scale_q    <= {1'b0, quo_new};
					draining_q <= 1'b1;
				end
			end
			// output register and drain bookkeeping
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					fill_q     <= '0;
					read_q     <= '0;
					peak_q     <= '0;
					draining_q <= 1'b0;
				end else begin
					read_q <= read_q + 1'b1;
				end
			end else if (sample_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (store_ok) begin
			store_q[fill_q[pnsc_pkg::ADDR_W-1:0]] <= sample_in.mixed_sample;
		end
		data_q <= store_q[read_q[pnsc_pkg::ADDR_W-1:0]];
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (pull_ok) begin
			last_q <= (read_q + 1'b1) == fill_q;
		end
		if (close_ok) begin
			rem_q <= pnsc_pkg::PEAK_W'(pnsc_pkg::FULL_SCALE);
			quo_q <= '0;
		end else if (state_q == pnsc_pkg::ST_DIV) begin
			rem_q <= rem_ge ? rem_diff[pnsc_pkg::PEAK_W-1:0] : rem_sh[pnsc_pkg::PEAK_W-1:0];
			quo_q <= quo_new;
		end
		if ((state_q == pnsc_pkg::ST_MULV) || (state_q == pnsc_pkg::ST_MULS)) begin
			prod_q <= mul_p;
		end
		if (state_q == pnsc_pkg::ST_CLIP) begin
			over_q  <= over;
			under_q <= under;
			b16_q   <= b_val[pnsc_pkg::OUT_W-1:0];
		end
		if (out_load) begin
			out_sample_q <= result;
			out_last_q   <= last_q;
		end
	end

	assign sample_in.ready            = in_ready;
	assign sample_out.valid           = out_valid_q;
	assign sample_out.limited_sample  = $signed(out_sample_q);
	assign sample_out.block_last      = out_last_q;

	// the divider only runs for a peak above the threshold
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pnsc_pkg::ST_DIV) |-> (peak_q > pnsc_pkg::PEAK_THRESHOLD))
		else $error("divider running with peak at or below threshold");

	// a draining block is never empty and the read pointer stays inside it
	assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> ((fill_q != '0) && (read_q < fill_q)))
		else $error("drain pointer outside the filled block");

	// emitting the last sample of a block ends the drain
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> (!draining_q && (fill_q == '0)))
		else $error("block not released after its last sample");

	// a scale below unity only comes out of the divider
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(draining_q) && (scale_q != pnsc_pkg::UNITY_SCALE))
		|-> ($past(state_q) == pnsc_pkg::ST_DIV))
		else $error("reduced scale without a division");

endmodule

[tb/peak_normalize_soft_clip_stage_tb.sv]
// self-checking testbench for the peak normalizer with soft clip
`timescale 1ns / 100ps

module peak_normalize_soft_clip_stage_tb;

	localparam int SETTLE_CYCLES    = 32;
	localparam int HOLD_CYCLES      = 200;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SEGMENTS         = 10;
	localparam int SEGMENT_ITEMS    = 20;
	localparam int FULL_DRAIN_ITEMS = 48;
	localparam int REPORT_LIMIT     = 10;

	localparam logic signed [pnsc_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
		{1'b1, {(pnsc_pkg::SAMPLE_W-1){1'b0}}};
	localparam logic signed [pnsc_pkg::SAMPLE_W-1:0] SAMPLE_MAX = ~SAMPLE_MIN;

	// content mixes for random blocks
	typedef enum int {
		MIX_WIDE,
		MIX_KNEE,
		MIX_QUIET
	} sample_mix_t;

	typedef struct packed {
		logic signed [pnsc_pkg::OUT_W-1:0] sample;
		logic                              last;
	} limited_item_t;

	// block predictor plus queue of limited samples still owed by the block
	class limiter_scoreboard;
		logic signed [pnsc_pkg::SAMPLE_W-1:0] store [pnsc_pkg::BLOCK_SAMPLES];
		logic [pnsc_pkg::KNEE_W-1:0]          knee [pnsc_pkg::CLIP_TABLE_DEPTH];
		int                                   fill;
		int                                   rd_ptr;
		int                                   peak;
		int                                   scale;
		bit                                   draining;
		logic [pnsc_pkg::VOL_W-1:0]           volume;
		limited_item_t                        owed_q[$];
		int                                   fails;

		function new();
			longint unsigned term;
			longint unsigned pos;
			longint unsigned neg;
			// soft-knee curve, alternating series in Q32
			for (int d = 0; d < pnsc_pkg::CLIP_TABLE_DEPTH; d++) begin
				term = longint'(d) << 32;
				pos  = 0;
				neg  = 0;
				for (int k = 1; k <= 12 && term != 0; k++) begin
					if (k % 2 == 1) begin
						pos += term;
					end else begin
						neg += term;
					end
					term = (term * longint'(d)) / (longint'(k + 1) * pnsc_pkg::FULL_SCALE);
				end
				knee[d] = pnsc_pkg::KNEE_W'((pos - neg) >> 32);
			end
			fill     = 0;
			rd_ptr   = 0;
			peak     = 0;
			scale    = int'(pnsc_pkg::UNITY_SCALE);
			draining = 1'b0;
			volume   = 8'd255;
			fails    = 0;
		endfunction

		function void set_volume(logic [pnsc_pkg::VOL_W-1:0] v);
			volume = v;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_input(logic op, logic signed [pnsc_pkg::SAMPLE_W-1:0] smp,
			logic fin);
			int            mag;
			int            ovr_dist;
			int            result;
			longint        prod;
			longint        vol_adj;
			longint        scaled;
			limited_item_t item;
			// push: store, track peak, close on block end
			if (op == pnsc_pkg::OP_PUSH) begin
				if (draining) begin
					return;
				end
				if (fill < pnsc_pkg::BLOCK_SAMPLES) begin
					store[fill] = smp;
					fill++;
					mag = (smp < 0) ? -int'(smp) : int'(smp);
					if (mag > peak) begin
						peak = mag;
					end
				end
				if (fin && fill != 0) begin
					if (peak > int'(pnsc_pkg::PEAK_THRESHOLD)) begin
						scale = int'((longint'(pnsc_pkg::FULL_SCALE) << pnsc_pkg::SCALE_FRAC)
							/ peak);
					end else begin
						scale = int'(pnsc_pkg::UNITY_SCALE);
					end
					rd_ptr   = 0;
					draining = 1'b1;
				end
				return;
			end
			// pull only yields while draining
			if (!draining || rd_ptr >= fill) begin
				return;
			end
			prod    = longint'(store[rd_ptr]) * longint'(volume);
			vol_adj = prod >>> 8;
			scaled  = (vol_adj * longint'(scale)) / 65536;
			// fold overshoot back through the knee curve
			if (scaled > pnsc_pkg::FULL_SCALE) begin
				ovr_dist = (scaled - pnsc_pkg::FULL_SCALE >= pnsc_pkg::CLIP_TABLE_DEPTH) ?
					pnsc_pkg::CLIP_TABLE_DEPTH - 1 : int'(scaled - pnsc_pkg::FULL_SCALE);
				result = pnsc_pkg::FULL_SCALE - int'(knee[ovr_dist]);
			end else if (scaled < -pnsc_pkg::FULL_SCALE - 1) begin
				ovr_dist = (-pnsc_pkg::FULL_SCALE - 1 - scaled >= pnsc_pkg::CLIP_TABLE_DEPTH)
					? pnsc_pkg::CLIP_TABLE_DEPTH - 1
					: int'(-pnsc_pkg::FULL_SCALE - 1 - scaled);
				result = -pnsc_pkg::FULL_SCALE - 1 + int'(knee[ovr_dist]);
			end else begin
				result = int'(scaled);
			end
			item.sample = pnsc_pkg::OUT_W'(result);
			item.last   = (rd_ptr + 1 == fill);
			owed_q.push_back(item);
			rd_ptr++;
			// end of drain returns to loading
			if (item.last) begin
				fill     = 0;
				rd_ptr   = 0;
				peak     = 0;
				draining = 1'b0;
			end
		endfunction

		function void check_result(logic signed [pnsc_pkg::OUT_W-1:0] smp, logic lst);
			limited_item_t want;
			if (owed_q.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT) begin
					$display("unexpected limited sample %0d last %0b", smp, lst);
				end
				return;
			end
			want = owed_q.pop_front();
			if (want.sample !== smp || want.last !== lst) begin
				fails++;
				if (fails <= REPORT_LIMIT) begin
					$display("limited sample: expected %0d last %0b, got %0d last %0b",
						want.sample, want.last, smp, lst);
				end
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [pnsc_pkg::VOL_W-1:0] cfg_wdata;

	pnsc_in_if  in_ch ();
	pnsc_out_if out_ch ();

	limiter_scoreboard sb;

	int src_idle_pct;
	int snk_idle_pct;
	bit hold_request;
	int hold_left;
	int stall_cycles;

	peak_normalize_soft_clip_stage i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (in_ch),
		.sample_out (out_ch)
	);

	// clock
	always #1 clk = ~clk;

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// monitor both channels, watchdog on cycles without any item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.opcode, in_ch.mixed_sample, in_ch.block_end);
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.limited_sample, out_ch.block_last);
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("peak_normalize_soft_clip_stage: mismatch");
					$finish;
				end
			end
		end
	end

	// offer one item and wait until it is taken
	task automatic drive_item(input logic op,
		input logic signed [pnsc_pkg::SAMPLE_W-1:0] smp, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.opcode       <= op;
		in_ch.mixed_sample <= smp;
		in_ch.block_end    <= fin;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	function automatic logic signed [pnsc_pkg::SAMPLE_W-1:0] pick_sample(sample_mix_t mix);
		int mag;
		case (mix)
			MIX_WIDE: begin
				if ($urandom_range(15) == 0) begin
					return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
				end
				return pnsc_pkg::SAMPLE_W'($urandom);
			end
			MIX_KNEE: begin
				mag = $urandom_range(34405, 30000);
				return pnsc_pkg::SAMPLE_W'($urandom_range(1) ? -mag : mag);
			end
			default: begin
				return pnsc_pkg::SAMPLE_W'(int'($urandom_range(65535)) - 32768);
			end
		endcase
	endfunction

	// pushes of one block; spill pushes land past a full store
	task automatic load_block(input int count, input sample_mix_t mix, input int spill);
		for (int i = 0; i < count + spill; i++) begin
			if ($urandom_range(99) < 4) begin
				drive_item(pnsc_pkg::OP_PULL, pnsc_pkg::SAMPLE_W'($urandom), 1'($urandom));
			end
			drive_item(pnsc_pkg::OP_PUSH, (i < count) ? pick_sample(mix) : SAMPLE_MIN,
				i == count + spill - 1);
		end
	endtask

	// pulls, with the odd ignored push mixed in
	task automatic drain_block(input int count);
		for (int i = 0; i < count && i < pnsc_pkg::BLOCK_SAMPLES; i++) begin
			if ($urandom_range(99) < 4) begin
				drive_item(pnsc_pkg::OP_PUSH, pnsc_pkg::SAMPLE_W'($urandom), 1'($urandom));
			end
			drive_item(pnsc_pkg::OP_PULL, pnsc_pkg::SAMPLE_W'($urandom), 1'($urandom));
		end
	endtask

	// stop offering until every owed item is back and the block is quiet
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_volume(input logic [pnsc_pkg::VOL_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_volume(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                         seg_items;
		int                         size;
		logic [pnsc_pkg::VOL_W-1:0] vol;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.opcode        = pnsc_pkg::OP_PUSH;
		in_ch.mixed_sample  = '0;
		in_ch.block_end     = 1'b0;
		out_ch.ready        = 1'b0;
		src_idle_pct        = 24;
		snk_idle_pct        = 49;
		hold_request        = 1'b0;
		hold_left           = 0;
		stall_cycles        = 0;
		sb                  = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pull while loading is ignored
		drive_item(pnsc_pkg::OP_PULL, '0, 1'b1);
		// field extremes, scale far below unity
		drive_item(pnsc_pkg::OP_PUSH, SAMPLE_MAX, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, SAMPLE_MIN, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, '0, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, -21'sd1, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, 21'sd34406, 1'b1);
		// push while draining is ignored, block end included
		drive_item(pnsc_pkg::OP_PUSH, SAMPLE_MAX, 1'b1);
		drain_block(5);
		// peak right at the threshold: unity scale, both sides clip
		drive_item(pnsc_pkg::OP_PUSH, 21'sd34405, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, -21'sd34405, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, 21'sd32767, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, -21'sd32768, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, 21'sd32768, 1'b0);
		drive_item(pnsc_pkg::OP_PUSH, -21'sd32769, 1'b1);
		drain_block(6);
		// one-sample block just over the threshold
		drive_item(pnsc_pkg::OP_PUSH, 21'sd34406, 1'b1);
		drain_block(1);
		// volume change in the middle of a drain
		load_block(4, MIX_KNEE, 0);
		drain_block(2);
		settle();
		write_volume(8'd128);
		drain_block(2);
		settle();
		write_volume(8'd255);

		// random blocks over volume settings and idling modes
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: vol = 8'd0;
				1: vol = 8'd255;
				2: vol = 8'd1;
				4: vol = 8'd128;
				5: vol = 8'd255;
				7: vol = 8'd255;
				8: vol = 8'd64;
				default: vol = pnsc_pkg::VOL_W'($urandom_range(254, 2));
			endcase
			write_volume(vol);
			if (seg == 4) begin
				src_idle_pct = 49;
				snk_idle_pct = 24;
			end else if (seg == 7) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			seg_items = 0;
			while (seg_items < SEGMENT_ITEMS) begin
				size = ($urandom_range(19) == 0) ? $urandom_range(80, 25) : $urandom_range(12, 1);
				load_block(size, sample_mix_t'($urandom_range(2)), 0);
				// receiver holds off while pulls keep coming
				if (seg == 5 && seg_items == 0) begin
					hold_request = 1'b1;
				end
				drain_block(size);
				seg_items += 2 * size;
			end
			settle();
		end

		// full store, dropped pushes must not move the peak
		load_block(pnsc_pkg::BLOCK_SAMPLES, MIX_QUIET, 6);
		drain_block(FULL_DRAIN_ITEMS);
		settle();

		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("peak_normalize_soft_clip_stage: match");
		end else begin
			$display("peak_normalize_soft_clip_stage: mismatch");
		end
		$finish;
	end

endmodule
